// File: hw/rtl/fbst_pkg.sv
// ----------------------------------------------------------------------------
// fbst_pkg
// Shared types and constants for the frame-buffer slot table.
// ----------------------------------------------------------------------------
package fbst_pkg;

  localparam int CMD_W = 2;
  localparam int OC_W  = 32;
  localparam int FC_W  = 16;
  localparam int IDX_W = 4;
  localparam int ST_W  = 2;
  localparam int ACT_W = 5;

  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOOKUP  = 2'd2
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // table update request from the command logic
  typedef struct packed {
    logic            alloc_en;
    logic            free_en;
    logic [OC_W-1:0] oc;
    logic [FC_W-1:0] fc;
  } upd_t;

endpackage

// File: hw/rtl/frame_buffer_slot_table.sv
// ----------------------------------------------------------------------------
// frame_buffer_slot_table
// Encoder frame-buffer slot table: allocate, release and lookup commands.
// ----------------------------------------------------------------------------
// datapath: input register, then one compare-and-pick pass into the result
//   register, which raises the result strobe
// throughput: one command per cycle; busy is low whenever reset is low
// reset: all slots free, active_slots back to 16; the receiver cannot stall
module frame_buffer_slot_table #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [fbst_pkg::ACT_W-1:0] cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic [fbst_pkg::CMD_W-1:0] cmd,
  input  logic [fbst_pkg::OC_W-1:0]  order_count,
  input  logic [fbst_pkg::FC_W-1:0]  frame_counter,
  output logic                       done,
  output logic [fbst_pkg::IDX_W-1:0] slot_index,
  output logic [fbst_pkg::FC_W-1:0]  held_counter,
  output logic [fbst_pkg::ST_W-1:0]  status
);

  import fbst_pkg::*;

  localparam int SW = $clog2(MAX_SLOTS);

  logic [ACT_W-1:0]     active_slots;
  logic                 valid;
  logic [CMD_W-1:0]     cmd_q;
  logic [OC_W-1:0]      oc_q;
  logic [FC_W-1:0]      fc_q;

  logic [MAX_SLOTS-1:0] free_vec;
  logic [MAX_SLOTS-1:0] oc_hit_vec;
  logic [MAX_SLOTS-1:0] fc_hit_vec;
  logic [SW-1:0]        free_idx;
  logic                 free_found;
  logic [SW-1:0]        oc_idx;
  logic                 oc_found;
  logic [FC_W-1:0]      rd_fc;

  upd_t                 upd;
  logic [SW-1:0]        upd_idx;
  logic [IDX_W-1:0]     slot_index_next;
  logic [FC_W-1:0]      held_counter_next;
  logic [ST_W-1:0]      status_next;

  assign busy = rst;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= ACT_RESET;
    end else if (cfg_we) begin
      active_slots <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      cmd_q <= cmd;
      oc_q  <= order_count;
      fc_q  <= frame_counter;
    end
  end

  fbst_table #(
    .MAX_SLOTS (MAX_SLOTS),
    .SW        (SW)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .active_slots (active_slots),
    .upd          (upd),
    .upd_idx      (upd_idx),
    .key_oc       (oc_q),
    .key_fc       (fc_q),
    .rd_idx       (oc_idx),
    .free_vec     (free_vec),
    .oc_hit_vec   (oc_hit_vec),
    .fc_hit_vec   (fc_hit_vec),
    .rd_fc        (rd_fc)
  );

  fbst_lowest #(
    .N  (MAX_SLOTS),
    .IW (SW)
  ) u_pick_free (
    .req   (free_vec),
    .idx   (free_idx),
    .found (free_found)
  );

  fbst_lowest #(
    .N  (MAX_SLOTS),
    .IW (SW)
  ) u_pick_match (
    .req   (oc_hit_vec),
    .idx   (oc_idx),
    .found (oc_found)
  );

  // command decision and table update
  always_comb begin
    slot_index_next   = '0;
    held_counter_next = '0;
    status_next       = ST_NOTFOUND;
    upd               = '0;
    upd.oc            = oc_q;
    upd.fc            = fc_q;
    upd_idx           = free_idx;
    case (cmd_q) inside
      CMD_ALLOC: begin
        if (|fc_hit_vec) begin
          status_next = ST_DUP;
        end else if (free_found) begin
          status_next       = ST_OK;
          slot_index_next   = IDX_W'(free_idx);
          held_counter_next = fc_q;
          upd.alloc_en      = valid;
        end else begin
          status_next = ST_FULL;
        end
      end
      CMD_RELEASE, CMD_LOOKUP: begin
        upd_idx = oc_idx;
        if (oc_found) begin
          status_next       = ST_OK;
          slot_index_next   = IDX_W'(oc_idx);
          held_counter_next = rd_fc;
          upd.free_en       = valid & (cmd_q == CMD_RELEASE);
        end
      end
      default: begin
        status_next = ST_NOTFOUND;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid) begin
      slot_index   <= slot_index_next;
      held_counter <= held_counter_next;
      status       <= status_next;
    end
  end

endmodule

// File: hw/rtl/fbst_lowest.sv
// ----------------------------------------------------------------------------
// fbst_lowest
// Priority pick: index of the lowest set bit of a request vector.
// ----------------------------------------------------------------------------
module fbst_lowest #(
  parameter int N  = 16,
  parameter int IW = 4
) (
  input  logic [N-1:0]  req,
  output logic [IW-1:0] idx,
  output logic          found
);

  // scan from the top so the lowest set bit wins
  always_comb begin
    idx   = '0;
    found = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx   = IW'(i);
        found = 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/fbst_table.sv
// ----------------------------------------------------------------------------
// fbst_table
// Slot storage with per-slot occupied flags and parallel match lanes.
// ----------------------------------------------------------------------------
module fbst_table #(
  parameter int MAX_SLOTS = 16,
  parameter int SW        = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [fbst_pkg::ACT_W-1:0] active_slots,
  input  fbst_pkg::upd_t           upd,
  input  logic [SW-1:0]            upd_idx,
  input  logic [fbst_pkg::OC_W-1:0] key_oc,
  input  logic [fbst_pkg::FC_W-1:0] key_fc,
  input  logic [SW-1:0]            rd_idx,
  output logic [MAX_SLOTS-1:0]     free_vec,
  output logic [MAX_SLOTS-1:0]     oc_hit_vec,
  output logic [MAX_SLOTS-1:0]     fc_hit_vec,
  output logic [fbst_pkg::FC_W-1:0] rd_fc
);

  import fbst_pkg::*;

  logic [MAX_SLOTS-1:0] occupied;
  logic [OC_W-1:0]      slot_oc [MAX_SLOTS];
  logic [FC_W-1:0]      slot_fc [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] active;

  // per-slot compare lanes, limited to the active range
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_lane
    assign active[i]     = 32'(active_slots) > i;
    assign free_vec[i]   = active[i] & ~occupied[i];
    assign oc_hit_vec[i] = active[i] & occupied[i] & (slot_oc[i] == key_oc);
    assign fc_hit_vec[i] = active[i] & occupied[i] & (slot_fc[i] == key_fc);
  end

  assign rd_fc = slot_fc[rd_idx];

  // occupied flags
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else if (upd.alloc_en) begin
      occupied[upd_idx] <= 1'b1;
    end else if (upd.free_en) begin
      occupied[upd_idx] <= 1'b0;
    end
  end

  // slot payload, written on allocate only
  always_ff @(posedge clk) begin
    if (upd.alloc_en) begin
      slot_oc[upd_idx] <= upd.oc;
      slot_fc[upd_idx] <= upd.fc;
    end
  end

endmodule

// File: tb/tb_frame_buffer_slot_table.sv
// ----------------------------------------------------------------------------
// tb_frame_buffer_slot_table
// Self-checking bench for the frame-buffer slot table. A scoreboard keeps its
// own copy of the slot table and the active count, predicts the answer to
// every accepted command and checks each strobed result in order. Directed
// commands hit the edge values and corner behaviors, then random phases at
// several active-slot settings mix allocate, release and lookup.
// ----------------------------------------------------------------------------
module tb_frame_buffer_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  import fbst_pkg::*;

  localparam int SLOTS = 16;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 120;
  localparam int EMPTY_PHASE_ITEMS = 30;
  localparam int QUIET_PHASE = 6;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // one expected answer from the table
  typedef struct {
    logic [IDX_W-1:0] slot;
    logic [FC_W-1:0]  counter;
    status_t          st;
  } slot_answer_t;

  // shadow slot table and queue of pending answers
  class slot_table_scoreboard;
    bit               occupied[SLOTS];
    logic [OC_W-1:0]  slot_oc[SLOTS];
    logic [FC_W-1:0]  slot_fc[SLOTS];
    logic [ACT_W-1:0] active;
    slot_answer_t     answers[$];
    int               errors;
    int               checked;
    int               status_seen[4];

    function new();
      int i;
      active = ACT_RESET;
      for (i = 0; i < SLOTS; i++) begin
        occupied[i] = 1'b0;
        slot_oc[i] = '0;
        slot_fc[i] = '0;
      end
      errors = 0;
      checked = 0;
      for (i = 0; i < 4; i++) status_seen[i] = 0;
    endfunction

    function void set_active(logic [ACT_W-1:0] value);
      active = value;
    endfunction

    // counts above the table size act as the full table
    function int live_slots();
      return (active > SLOTS) ? SLOTS : int'(active);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // work out the answer to an accepted command and update the shadow table
    function void note_command(logic [CMD_W-1:0] c, logic [OC_W-1:0] oc,
                               logic [FC_W-1:0] fc);
      slot_answer_t ans;
      int n;
      int hit;
      int i;
      bit dup;
      n = live_slots();
      hit = -1;
      dup = 1'b0;
      ans.slot = '0;
      ans.counter = '0;
      ans.st = ST_NOTFOUND;
      case (c)
        CMD_ALLOC: begin
          for (i = 0; i < n; i++)
            if (occupied[i] && slot_fc[i] == fc) dup = 1'b1;
          if (dup) begin
            ans.st = ST_DUP;
          end else begin
            ans.st = ST_FULL;
            for (i = 0; i < n; i++)
              if (!occupied[i] && hit < 0) hit = i;
            if (hit >= 0) begin
              occupied[hit] = 1'b1;
              slot_oc[hit] = oc;
              slot_fc[hit] = fc;
              ans.slot = IDX_W'(hit);
              ans.counter = fc;
              ans.st = ST_OK;
            end
          end
        end
        CMD_RELEASE, CMD_LOOKUP: begin
          for (i = 0; i < n; i++)
            if (occupied[i] && slot_oc[i] == oc && hit < 0) hit = i;
          if (hit >= 0) begin
            ans.slot = IDX_W'(hit);
            ans.counter = slot_fc[hit];
            ans.st = ST_OK;
            if (c == CMD_RELEASE) occupied[hit] = 1'b0;
          end
        end
        default: ;
      endcase
      answers.push_back(ans);
    endfunction

    // compare one strobed result with the oldest pending answer
    task check_result(logic [IDX_W-1:0] idx, logic [FC_W-1:0] held,
                      logic [ST_W-1:0] st);
      slot_answer_t want;
      if (answers.size() == 0) begin
        report($sformatf("result with nothing pending: slot %0d counter %0h status %0d",
                         idx, held, st));
      end else begin
        want = answers.pop_front();
        checked++;
        status_seen[want.st]++;
        if (st !== want.st)
          report($sformatf("status %0d, expected %s", st, want.st.name()));
        if (idx !== want.slot)
          report($sformatf("slot_index %0d, expected %0d", idx, want.slot));
        if (held !== want.counter)
          report($sformatf("held_counter %0h, expected %0h", held, want.counter));
      end
    endtask

    task check_leftover();
      if (answers.size() != 0)
        report($sformatf("%0d answers never arrived", answers.size()));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [ACT_W-1:0] cfg_wdata;
  logic             start;
  logic             busy;
  logic [CMD_W-1:0] cmd;
  logic [OC_W-1:0]  order_count;
  logic [FC_W-1:0]  frame_counter;
  logic             done;
  logic [IDX_W-1:0] slot_index;
  logic [FC_W-1:0]  held_counter;
  logic [ST_W-1:0]  status;

  slot_table_scoreboard sb = new();
  int sent_items = 0;
  int settings_used = 0;

  frame_buffer_slot_table #(.MAX_SLOTS(SLOTS)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .order_count(order_count),
    .frame_counter(frame_counter),
    .done(done),
    .slot_index(slot_index),
    .held_counter(held_counter),
    .status(status)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result monitor: the strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(slot_index, held_counter, status);
  end

  // present one command and wait for its transfer
  task automatic send_command(logic [CMD_W-1:0] c, logic [OC_W-1:0] oc,
                              logic [FC_W-1:0] fc);
    start <= 1'b1;
    cmd <= c;
    order_count <= oc;
    frame_counter <= fc;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(c, oc, fc);
    sent_items++;
  endtask

  // random sender gap: taken with a chance of 14 in a hundred, lengthened while further draws hit
  task automatic idle_gap();
    int n;
    n = 0;
    while ($urandom_range(99) < 14) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait until every pending answer has come back and the pipe is empty
  task automatic drain_results();
    start <= 1'b0;
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // active-slot register write, only while the table is idle
  task automatic write_active(logic [ACT_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_active(value);
    settings_used++;
  endtask

  // random command, partly aimed at order counts and frame counters in the table
  task automatic pick_command(output logic [CMD_W-1:0] c, output logic [OC_W-1:0] oc,
                              output logic [FC_W-1:0] fc);
    int r;
    int s;
    int n;
    n = sb.live_slots();
    r = $urandom_range(99);
    if (r < 42) c = CMD_ALLOC;
    else if (r < 70) c = CMD_RELEASE;
    else if (r < 96) c = CMD_LOOKUP;
    else c = CMD_UNUSED;
    if (n > 0 && $urandom_range(99) < 80) s = $urandom_range(n - 1);
    else s = $urandom_range(SLOTS - 1);
    r = $urandom_range(99);
    if (c != CMD_ALLOC && r < 70 && sb.occupied[s]) oc = sb.slot_oc[s];
    else if (r < 50) oc = OC_W'($signed($urandom_range(64)) - 32);
    else oc = $urandom;
    r = $urandom_range(99);
    if (r < 25 && sb.occupied[s]) fc = sb.slot_fc[s];
    else if (r < 65) fc = FC_W'($urandom_range(63));
    else fc = FC_W'($urandom);
  endtask

  // timeout
  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("tb_frame_buffer_slot_table failed");
    $finish;
  end

  // stimulus
  initial begin
    logic [ACT_W-1:0] phase_active[NUM_PHASES];
    logic [CMD_W-1:0] c;
    logic [OC_W-1:0]  oc;
    logic [FC_W-1:0]  fc;
    int p;
    int k;
    int items;
    phase_active = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd16, 5'd9, 5'd16};
    phase_active[8] = ACT_W'($urandom_range(1, 16));
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    start <= 1'b0;
    cmd <= CMD_ALLOC;
    order_count <= '0;
    frame_counter <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, unused command, sign extremes, repeated order count
    send_command(CMD_LOOKUP, 32'h0000_0000, 16'h0000);
    send_command(CMD_RELEASE, 32'h0000_0000, 16'h0000);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(CMD_ALLOC, 32'h8000_0000, 16'hFFFF);
    send_command(CMD_ALLOC, 32'h7FFF_FFFF, 16'h0000);
    send_command(CMD_ALLOC, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(CMD_ALLOC, 32'h8000_0000, 16'h0001);
    send_command(CMD_LOOKUP, 32'h8000_0000, 16'h1234);
    send_command(CMD_RELEASE, 32'h8000_0000, 16'h0000);
    send_command(CMD_LOOKUP, 32'h8000_0000, 16'h0000);
    send_command(CMD_ALLOC, 32'h0000_0000, 16'h8000);
    send_command(CMD_LOOKUP, 32'h7FFF_FFFF, 16'h0000);
    send_command(CMD_RELEASE, 32'h7FFF_FFFF, 16'h0000);
    send_command(CMD_RELEASE, 32'h7FFF_FFFF, 16'h0000);
    send_command(CMD_ALLOC, 32'h5555_5555, 16'hAAAA);
    send_command(CMD_LOOKUP, 32'hAAAA_AAAA, 16'h5555);

    // directed: slots beyond the active count are hidden but kept
    write_active(5'd2);
    send_command(CMD_ALLOC, 32'h0000_0001, 16'h0002);
    send_command(CMD_LOOKUP, 32'h8000_0000, 16'h0000);
    send_command(CMD_RELEASE, 32'h0000_0000, 16'h0000);
    send_command(CMD_ALLOC, 32'h0000_0003, 16'h0001);

    // directed: no active slot at all
    write_active(5'd0);
    send_command(CMD_ALLOC, 32'h0000_0004, 16'h0004);
    send_command(CMD_RELEASE, 32'h0000_0003, 16'h0000);
    send_command(CMD_LOOKUP, 32'h0000_0003, 16'h0000);

    // directed: oversized count acts as the full table
    write_active(5'd31);
    send_command(CMD_LOOKUP, 32'h8000_0000, 16'h0000);
    send_command(CMD_ALLOC, 32'h0000_0004, 16'h0001);

    // random phases over several active-slot settings
    for (p = 0; p < NUM_PHASES; p++) begin
      write_active(phase_active[p]);
      items = (phase_active[p] == 0) ? EMPTY_PHASE_ITEMS : PHASE_ITEMS;
      for (k = 0; k < items; k++) begin
        if (p != QUIET_PHASE) idle_gap();
        pick_command(c, oc, fc);
        send_command(c, oc, fc);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    sb.check_leftover();
    $display("covered %0d commands over %0d active-slot settings", sent_items, settings_used);
    $display("answers: %0d ok, %0d duplicate, %0d full, %0d not found",
             sb.status_seen[ST_OK], sb.status_seen[ST_DUP], sb.status_seen[ST_FULL],
             sb.status_seen[ST_NOTFOUND]);
    if (sb.errors == 0) begin
      $display("tb_frame_buffer_slot_table passed");
    end else begin
      $display("tb_frame_buffer_slot_table failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/fbst_pkg.sv
hw/rtl/fbst_lowest.sv
hw/rtl/fbst_table.sv
hw/rtl/frame_buffer_slot_table.sv
tb/tb_frame_buffer_slot_table.sv
